>>> rtl/core/spc_pkg.sv
// Package for the segmented prime counter.
// Holds field widths and the sequencer state type; no dependencies.
package spc_pkg;

    localparam int FIELD_W = 24;
    localparam int COUNT_W = 25;
    // Wide enough for a segment base plus one segment at the largest segment size.
    localparam int VAL_W   = 26;

    typedef enum logic [4:0] {
        ST_B_CLR,
        ST_B_SQ,
        ST_B_CHK,
        ST_B_MARK,
        ST_COL_RD,
        ST_COL_WR,
        ST_IDLE,
        ST_SEG_INIT,
        ST_FILL,
        ST_P_RD,
        ST_P_LD,
        ST_P_SQ,
        ST_P_CHK,
        ST_P_DIV,
        ST_P_START,
        ST_S_TEST,
        ST_S_WR,
        ST_SC_RD,
        ST_SC_ACC,
        ST_FIN
    } spc_state_t;

endpackage

>>> rtl/core/spc_if.sv
// Valid/ready channel interfaces for the segmented prime counter.
// Depends on spc_pkg for the field widths.
interface spc_job_if;
    logic                          valid;
    logic                          ready;
    logic [spc_pkg::FIELD_W-1:0]   range_low;
    logic [spc_pkg::FIELD_W-1:0]   range_high;

    modport source (output valid, output range_low, output range_high, input ready);
    modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

interface spc_result_if;
    logic                          valid;
    logic                          ready;
    logic [spc_pkg::COUNT_W-1:0]   prime_count;

    modport source (output valid, output prime_count, input ready);
    modport sink   (input valid, input prime_count, output ready);
endinterface

>>> rtl/core/segmented_prime_counter_unit.sv
// Segmented prime counter: counts the primes in an inclusive range.
// Depends on spc_pkg and the channel interfaces in spc_if.sv.
// Reset: a clearing pass over the mark table, a sieve over the candidates up to the square root
// that marks the multiples of each prime, then a pass over the numbers from 2 up to PRIME_LIMIT - 1
// to collect the table. Each job runs, for each segment, a fill of the bitmap, then per table prime a
// load, a square and, when the segment starts above the prime's square, the shared restoring divider,
// then a read-modify-write per strike, and last a read of the bitmap words up to the segment's end
// for the count.
// One job at a time; the result register lets the next job start while a result waits.
module segmented_prime_counter_unit #(
    parameter int PRIME_LIMIT  = 4001,
    parameter int SEGMENT_BITS = 32768
) (
    input  logic clk,
    input  logic rst_n,
    spc_job_if.sink      job,
    spc_result_if.source result
);
    import spc_pkg::*;

    localparam int MW        = $clog2(PRIME_LIMIT);
    localparam int BITMAP_WORDS = (SEGMENT_BITS + 31) / 32;
    localparam int WIW       = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int JW        = ((2 * MW > VAL_W) ? 2 * MW : VAL_W) + 1;
    localparam int CW        = $clog2(VAL_W + 1);

    spc_state_t state_reg, state_next;

    logic               mark_mem [PRIME_LIMIT];
    logic [MW-1:0]      tbl_mem  [PRIME_LIMIT];
    logic [31:0]        seg_mem  [BITMAP_WORDS];

    logic [MW-1:0]      idx_reg;
    logic [MW-1:0]      bi_reg;
    logic [MW:0]        bj_reg;
    logic [2*MW-1:0]    sq_reg;
    logic [MW-1:0]      tot_reg;
    logic [MW-1:0]      k_reg;
    logic [MW-1:0]      p_reg;
    logic [2*MW-1:0]    pp_reg;
    logic [JW-1:0]      j_reg;
    logic [MW-1:0]      rem_reg;
    logic [VAL_W-1:0]   dvd_reg;
    logic [CW-1:0]      dcnt_reg;
    logic [VAL_W-1:0]   base_reg;
    logic [VAL_W-1:0]   hi_reg;
    logic [VAL_W-1:0]   seg_hi_reg;
    logic [VAL_W-1:0]   len_reg;
    logic [WIW-1:0]     widx_reg;
    logic [WIW-1:0]     swaddr_reg;
    logic [4:0]         sbit_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               res_valid_reg;
    logic [COUNT_W-1:0] res_count_reg;

    logic               mark_rd_reg;
    logic [MW-1:0]      tbl_rd_reg;
    logic [31:0]        seg_rd_reg;

    logic [MW-1:0]      mark_raddr;
    logic               mark_we;
    logic [MW-1:0]      mark_waddr;
    logic               mark_wdata;
    logic               seg_we;
    logic [WIW-1:0]     seg_waddr;
    logic [31:0]        seg_wdata;
    logic [WIW-1:0]     seg_raddr;
    logic               tbl_we;

    logic               job_take;
    logic               res_load;
    logic [MW:0]        div_t;
    logic               div_ge;
    logic [MW:0]        div_diff;
    logic [MW-1:0]      div_rem;
    logic [JW-1:0]      start_val;
    logic [VAL_W-1:0]   spos;
    logic               j_past_end;
    logic [VAL_W-1:0]   seg_end;
    logic [32:0]        tail_mask;
    logic [31:0]        scan_word;
    logic               scan_last;

    assign job_take = job.valid && job.ready;
    assign res_load = (state_reg == ST_FIN) && (!res_valid_reg || result.ready);

    // Restoring divider step: one quotient bit of base / p per cycle, remainder kept.
    assign div_t    = {rem_reg, dvd_reg[VAL_W-1]};
    assign div_ge   = div_t >= {1'b0, p_reg};
    assign div_diff = div_t - {1'b0, p_reg};
    assign div_rem  = div_ge ? div_diff[MW-1:0] : div_t[MW-1:0];

    assign start_val  = JW'(base_reg) + ((rem_reg == '0) ? '0 : JW'(p_reg - rem_reg));
    assign spos       = VAL_W'(j_reg - JW'(base_reg));
    assign j_past_end = j_reg > JW'(seg_hi_reg);
    assign seg_end    = base_reg + VAL_W'(SEGMENT_BITS - 1);
    assign scan_last  = widx_reg == len_reg[WIW+4:5];
    assign tail_mask  = (33'd1 << ({28'd0, len_reg[4:0]} + 33'd1)) - 33'd1;

    always_comb
    begin
        scan_word = seg_rd_reg;
        if (scan_last)
        begin
            scan_word = scan_word & tail_mask[31:0];
        end
        // Zero and one are never prime; both can only sit in the first word.
        if (widx_reg == '0 && base_reg == '0)
        begin
            scan_word = scan_word & ~32'd3;
        end
        else if (widx_reg == '0 && base_reg == VAL_W'(1))
        begin
            scan_word = scan_word & ~32'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_B_CLR:    if (idx_reg == MW'(PRIME_LIMIT - 1)) state_next = ST_B_SQ;
            ST_B_SQ:     state_next = ST_B_CHK;
            ST_B_CHK:
            begin
                if (sq_reg >= (2*MW)'(PRIME_LIMIT))
                    state_next = ST_COL_RD;
                else if (mark_rd_reg)
                    state_next = ST_B_SQ;
                else
                    state_next = ST_B_MARK;
            end
            ST_B_MARK:   if (bj_reg >= (MW+1)'(PRIME_LIMIT)) state_next = ST_B_SQ;
            ST_COL_RD:   state_next = ST_COL_WR;
            ST_COL_WR:
            begin
                if (idx_reg == MW'(PRIME_LIMIT - 1))
                    state_next = ST_IDLE;
                else
                    state_next = ST_COL_RD;
            end
            ST_IDLE:
            begin
                if (job_take)
                begin
                    if (job.range_high < job.range_low)
                        state_next = ST_FIN;
                    else
                        state_next = ST_SEG_INIT;
                end
            end
            ST_SEG_INIT: state_next = ST_FILL;
            ST_FILL:     if (widx_reg == WIW'(BITMAP_WORDS - 1)) state_next = ST_P_RD;
            ST_P_RD:     state_next = ST_P_LD;
            ST_P_LD:     state_next = ST_P_SQ;
            ST_P_SQ:     state_next = ST_P_CHK;
            ST_P_CHK:
            begin
                if (JW'(base_reg) <= JW'(pp_reg))
                    state_next = ST_S_TEST;
                else
                    state_next = ST_P_DIV;
            end
            ST_P_DIV:    if (dcnt_reg == CW'(1)) state_next = ST_P_START;
            ST_P_START:  state_next = ST_S_TEST;
            ST_S_TEST:
            begin
                if (!j_past_end)
                    state_next = ST_S_WR;
                else if (k_reg == tot_reg - MW'(1))
                    state_next = ST_SC_RD;
                else
                    state_next = ST_P_RD;
            end
            ST_S_WR:     state_next = ST_S_TEST;
            ST_SC_RD:    state_next = ST_SC_ACC;
            ST_SC_ACC:
            begin
                if (!scan_last)
                    state_next = ST_SC_RD;
                else if (seg_hi_reg == hi_reg)
                    state_next = ST_FIN;
                else
                    state_next = ST_SEG_INIT;
            end
            ST_FIN:      if (res_load) state_next = ST_IDLE;
            default:     state_next = ST_B_CLR;
        endcase
    end

    always_comb
    begin
        job.ready    = state_reg == ST_IDLE;
        result.valid = res_valid_reg;
        result.prime_count = res_count_reg;

        mark_raddr = (state_reg == ST_B_SQ) ? bi_reg : idx_reg;
        mark_we    = (state_reg == ST_B_CLR) ||
                     ((state_reg == ST_B_MARK) && (bj_reg < (MW+1)'(PRIME_LIMIT)));
        mark_waddr = (state_reg == ST_B_CLR) ? idx_reg : bj_reg[MW-1:0];
        mark_wdata = state_reg != ST_B_CLR;

        tbl_we     = (state_reg == ST_COL_WR) && !mark_rd_reg;

        seg_we     = (state_reg == ST_FILL) || (state_reg == ST_S_WR);
        seg_waddr  = (state_reg == ST_FILL) ? widx_reg : swaddr_reg;
        seg_wdata  = (state_reg == ST_FILL) ? 32'hFFFF_FFFF
                                            : (seg_rd_reg & ~(32'd1 << sbit_reg));
        seg_raddr  = (state_reg == ST_S_TEST) ? spos[WIW+4:5] : widx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_rd_reg <= mark_mem[mark_raddr];
        if (tbl_we)
        begin
            tbl_mem[tot_reg] <= idx_reg;
        end
        tbl_rd_reg <= tbl_mem[k_reg];
        if (seg_we)
        begin
            seg_mem[seg_waddr] <= seg_wdata;
        end
        seg_rd_reg <= seg_mem[seg_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_B_CLR;
            idx_reg       <= '0;
            tot_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_B_CLR && idx_reg != MW'(PRIME_LIMIT - 1))
                idx_reg <= idx_reg + MW'(1);
            else if (state_reg == ST_B_CHK && sq_reg >= (2*MW)'(PRIME_LIMIT))
                idx_reg <= MW'(2);
            else if (state_reg == ST_COL_WR && idx_reg != MW'(PRIME_LIMIT - 1))
                idx_reg <= idx_reg + MW'(1);
            if (tbl_we)
                tot_reg <= tot_reg + MW'(1);
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_B_CLR:    bi_reg <= MW'(2);
            ST_B_SQ:     sq_reg <= (2*MW)'(bi_reg * bi_reg);
            ST_B_CHK:
            begin
                if (mark_rd_reg)
                    bi_reg <= bi_reg + MW'(1);
                bj_reg <= sq_reg[MW:0];
            end
            ST_B_MARK:
            begin
                if (bj_reg >= (MW+1)'(PRIME_LIMIT))
                    bi_reg <= bi_reg + MW'(1);
                else
                    bj_reg <= bj_reg + {1'b0, bi_reg};
            end
            ST_IDLE:
            begin
                base_reg  <= VAL_W'(job.range_low);
                hi_reg    <= VAL_W'(job.range_high);
                count_reg <= '0;
            end
            ST_SEG_INIT:
            begin
                seg_hi_reg <= (seg_end > hi_reg) ? hi_reg : seg_end;
                widx_reg   <= '0;
            end
            ST_FILL:
            begin
                len_reg  <= seg_hi_reg - base_reg;
                widx_reg <= widx_reg + WIW'(1);
                k_reg    <= '0;
            end
            ST_P_LD:     p_reg  <= tbl_rd_reg;
            ST_P_SQ:     pp_reg <= p_reg * p_reg;
            ST_P_CHK:
            begin
                j_reg    <= JW'(pp_reg);
                rem_reg  <= '0;
                dvd_reg  <= base_reg;
                dcnt_reg <= CW'(VAL_W);
            end
            ST_P_DIV:
            begin
                rem_reg  <= div_rem;
                dvd_reg  <= {dvd_reg[VAL_W-2:0], 1'b0};
                dcnt_reg <= dcnt_reg - CW'(1);
            end
            ST_P_START:  j_reg <= start_val;
            ST_S_TEST:
            begin
                swaddr_reg <= spos[WIW+4:5];
                sbit_reg   <= spos[4:0];
                if (j_past_end)
                begin
                    k_reg    <= k_reg + MW'(1);
                    widx_reg <= '0;
                end
            end
            ST_S_WR:     j_reg <= j_reg + JW'(p_reg);
            ST_SC_ACC:
            begin
                count_reg <= count_reg + COUNT_W'($countones(scan_word));
                widx_reg  <= widx_reg + WIW'(1);
                if (scan_last)
                    base_reg <= base_reg + VAL_W'(SEGMENT_BITS);
            end
            ST_FIN:      if (res_load) res_count_reg <= count_reg;
            default:
            begin
            end
        endcase
    end

    // A strike inside the segment always lands inside the bitmap.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_S_TEST && !j_past_end) |-> (spos < VAL_W'(SEGMENT_BITS)))
        else $error("strike position outside the segment bitmap");

    // The divider leaves a remainder below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_P_START) |-> (rem_reg < p_reg))
        else $error("divider remainder not below the prime");

    // Jobs are only taken once the prime table holds entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> (tot_reg != '0))
        else $error("job accepted before the prime table was built");

    // A result transaction is only loaded at the end of a job.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result raised outside the finish step");

endmodule
